// ===== design/braille_emboss_motion_sequencer_core_macros.svh =====
// assertion macros shared by the braille emboss motion sequencer
`ifndef BRAILLE_EMBOSS_MOTION_SEQUENCER_CORE_MACROS_SVH
`define BRAILLE_EMBOSS_MOTION_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BEMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BEMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer next-cycle check failed");

`endif

// ===== design/bems_pkg.sv =====
// types, codes, tables and helpers of the braille emboss motion sequencer
package bems_pkg;

  // item kinds on the input channel
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_HOME     = 3'd1;
  localparam logic [2:0] KIND_FEED_S   = 3'd2;
  localparam logic [2:0] KIND_FEED_L   = 3'd3;
  localparam logic [2:0] KIND_EMBOSS   = 3'd4;
  localparam logic [2:0] KIND_RELEASE  = 3'd5;

  // sequencer modes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_SEEK   = 3'd1;
  localparam logic [2:0] MODE_INDENT = 3'd2;
  localparam logic [2:0] MODE_FEED   = 3'd3;
  localparam logic [2:0] MODE_STRIKE = 3'd4;
  localparam logic [2:0] MODE_GAP    = 3'd5;

  // strike sub-steps
  localparam logic [1:0] STAGE_LEAD = 2'd0;
  localparam logic [1:0] STAGE_HOLD = 2'd1;
  localparam logic [1:0] STAGE_TAIL = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_STEP_TICKS   = 3'd0;
  localparam logic [2:0] CFG_STRIKE_TICKS = 3'd1;
  localparam logic [2:0] CFG_SHORT_FEED   = 3'd2;
  localparam logic [2:0] CFG_LONG_FEED    = 3'd3;
  localparam logic [2:0] CFG_INDENT       = 3'd4;
  localparam logic [2:0] CFG_NARROW_GAP   = 3'd5;
  localparam logic [2:0] CFG_WIDE_GAP     = 3'd6;

  // half-step coil order, forward
  localparam logic [7:0] PHASE_TABLE [8] = '{
    8'h77, 8'h33, 8'hbb, 8'h99, 8'hdd, 8'hcc, 8'hee, 8'h66
  };

  typedef struct packed {
    logic       hit;     // a stop was found at or below the start bit
    logic       strike;  // the stop is a strike, else a carriage gap
    logic [2:0] pos;     // bit position of the stop
  } scan_t;

  // drive the phase into the nibble of the motor that the mode moves
  function automatic logic [7:0] apply_phase(input logic [7:0] coils,
                                             input logic [2:0] mode,
                                             input logic [2:0] idx);
    logic       fwd;
    logic [7:0] v;
    fwd = (mode == MODE_SEEK) || (mode == MODE_FEED);
    v   = fwd ? PHASE_TABLE[idx] : PHASE_TABLE[~idx];
    if (mode == MODE_FEED) begin
      apply_phase = {v[7:4], coils[3:0]};
    end else begin
      apply_phase = {coils[7:4], v[3:0]};
    end
  endfunction

  // find the highest bit at or below pos that needs a strike or a gap
  function automatic scan_t scan_bits(input logic [7:0] pattern,
                                      input logic [2:0] pos,
                                      input logic       struck,
                                      input logic       narrow_nz,
                                      input logic       wide_nz);
    scan_t r;
    r = '0;
    for (int p = 0; p < 8; p++) begin
      if (3'(p) <= pos) begin
        if (pattern[p] && !(struck && (3'(p) == pos))) begin
          r.hit    = 1'b1;
          r.strike = 1'b1;
          r.pos    = 3'(p);
        end else if (p[0] ? narrow_nz : wide_nz) begin
          r.hit    = 1'b1;
          r.strike = 1'b0;
          r.pos    = 3'(p);
        end
      end
    end
    scan_bits = r;
  endfunction

endpackage

// ===== design/braille_emboss_motion_sequencer_core.sv =====
// top level of the braille emboss motion sequencer
//
// drives two half-step stepper motors (carriage on the low coil nibble,
// roller on the high nibble) and the embossing solenoid
// in channel: one transaction per item; tuser holds the kind (tick, home,
// feed short, feed long, emboss byte, release coils), tdata holds the dot
// byte and the carriage sensor, tlast marks the last byte of a line
// out channel: exactly one transaction per input item, showing coils,
// solenoid, busy, done, echo byte and the rejected flag after that item
// cfg channel: always ready, takes one register write per cycle; write only
// while no result is pending
// latency: an accepted item shows up on the out channel two cycles later
// (input register, then result register)
// throughput: one item per cycle; each item's state update is a single
// pass of short logic between the input register and the result register
// reset: mode idle, all coils and the solenoid off, timing and loop
// registers back to their defaults, both channels empty
// out stall: the result register holds, the input register fills, and then
// in_tready drops until the receiver takes the pending result
module braille_emboss_motion_sequencer_core
  import bems_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [8] carriage_away, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  input  logic        in_tlast,   // last_in_line
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] coil_pattern, [8] solenoid, [9] busy_res,
                                  // [10] done_res, [18:11] echo_byte, [19] rejected,
                                  // rest zero
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0] step_ticks_r, strike_ticks_r;
  logic [7:0]  short_feed_r, long_feed_r, indent_r, narrow_gap_r, wide_gap_r;

  // input register stage
  logic        s1_valid_r;
  logic [2:0]  s1_kind_r;
  logic [7:0]  s1_data_r;
  logic        s1_last_r;
  logic        s1_away_r;

  // sequencer state
  logic [2:0]  mode_r, mode_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  loops_r, loops_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  pattern_r, pattern_nxt;
  logic [7:0]  echo_r, echo_nxt;
  logic [7:0]  coils_r, coils_nxt;
  logic        striker_r, striker_nxt;
  logic [1:0]  stage_r, stage_nxt;
  logic        rel_r, rel_nxt;

  // result register
  logic        out_valid_r;
  logic [7:0]  out_coil_r;
  logic        out_sol_r, out_busy_r, out_done_r, out_rej_r;
  logic [7:0]  out_echo_r;

  // per-item work
  logic        advance;
  logic        work;
  logic        done, done_emb, rej;
  logic        mv_req;
  logic [2:0]  mv_mode;
  logic [7:0]  mv_loops;
  logic        fin_req, fin_rel, fin_emb;
  logic        scan_req, scan_struck;
  logic [2:0]  scan_pos;
  scan_t       scan_res;
  logic [2:0]  phase_inc;
  logic [7:0]  loops_dec;

  // the pipeline moves when the result register is free or being drained
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign work      = advance && s1_valid_r;
  assign cfg_ready = 1'b1;

  assign phase_inc = phase_r + 3'd1;
  assign loops_dec = loops_r - 8'd1;

  always_comb begin
    mode_nxt    = mode_r;
    phase_nxt   = phase_r;
    loops_nxt   = loops_r;
    wait_nxt    = wait_r;
    pos_nxt     = pos_r;
    pattern_nxt = pattern_r;
    echo_nxt    = echo_r;
    coils_nxt   = coils_r;
    striker_nxt = striker_r;
    stage_nxt   = stage_r;
    rel_nxt     = rel_r;
    done        = 1'b0;
    done_emb    = 1'b0;
    rej         = 1'b0;
    mv_req      = 1'b0;
    mv_mode     = MODE_IDLE;
    mv_loops    = 8'd0;
    fin_req     = 1'b0;
    fin_rel     = 1'b0;
    fin_emb     = 1'b0;
    scan_req    = 1'b0;
    scan_struck = 1'b0;
    scan_pos    = 3'd0;
    scan_res    = '0;

    if (work) begin
      case (s1_kind_r)
        KIND_TICK: begin
          if (mode_r != MODE_IDLE) begin
            if (wait_r > 16'd1) begin
              wait_nxt = wait_r - 16'd1;
            end else if (mode_r == MODE_STRIKE) begin
              case (stage_r)
                STAGE_LEAD: begin
                  striker_nxt = 1'b1;
                  stage_nxt   = STAGE_HOLD;
                  wait_nxt    = strike_ticks_r;
                end
                STAGE_HOLD: begin
                  striker_nxt = 1'b0;
                  stage_nxt   = STAGE_TAIL;
                  wait_nxt    = strike_ticks_r;
                end
                default: begin
                  // dot is done: record it and look for the next stop
                  stage_nxt   = STAGE_LEAD;
                  echo_nxt    = echo_r | (8'd1 << pos_r);
                  scan_req    = 1'b1;
                  scan_pos    = pos_r;
                  scan_struck = 1'b1;
                end
              endcase
            end else begin
              phase_nxt = phase_inc;
              if (phase_inc == 3'd0) begin
                loops_nxt = loops_dec;
              end
              if ((phase_inc == 3'd0) && (loops_dec == 8'd0)) begin
                // move has ended
                case (mode_r)
                  MODE_SEEK: begin
                    mv_req   = 1'b1;
                    mv_mode  = s1_away_r ? MODE_SEEK : MODE_INDENT;
                    mv_loops = s1_away_r ? 8'd1 : indent_r;
                  end
                  MODE_GAP: begin
                    if (pos_r == 3'd0) begin
                      fin_req = 1'b1;
                      fin_rel = rel_r;
                      fin_emb = 1'b1;
                    end else begin
                      pos_nxt  = pos_r - 3'd1;
                      scan_req = 1'b1;
                      scan_pos = pos_r - 3'd1;
                    end
                  end
                  default: begin
                    fin_req = 1'b1;
                    fin_rel = 1'b1;
                  end
                endcase
              end else begin
                coils_nxt = apply_phase(coils_r, mode_r, phase_inc);
                wait_nxt  = step_ticks_r;
              end
            end
          end
        end
        KIND_HOME, KIND_FEED_S, KIND_FEED_L, KIND_EMBOSS, KIND_RELEASE: begin
          if (mode_r != MODE_IDLE) begin
            rej = 1'b1;
          end else begin
            case (s1_kind_r)
              KIND_HOME: begin
                mv_req   = 1'b1;
                mv_mode  = s1_away_r ? MODE_SEEK : MODE_INDENT;
                mv_loops = s1_away_r ? 8'd1 : indent_r;
              end
              KIND_FEED_S: begin
                mv_req   = 1'b1;
                mv_mode  = MODE_FEED;
                mv_loops = short_feed_r;
              end
              KIND_FEED_L: begin
                mv_req   = 1'b1;
                mv_mode  = MODE_FEED;
                mv_loops = long_feed_r;
              end
              KIND_EMBOSS: begin
                pattern_nxt = s1_data_r;
                echo_nxt    = 8'd0;
                rel_nxt     = s1_last_r;
                pos_nxt     = 3'd7;
                scan_req    = 1'b1;
                scan_pos    = 3'd7;
              end
              default: begin
                fin_req = 1'b1;
                fin_rel = 1'b1;
              end
            endcase
          end
        end
        default: begin
          // undefined kinds pass through with no effect
        end
      endcase

      // walk down the byte to the next dot or non-empty gap
      if (scan_req) begin
        scan_res = scan_bits(pattern_nxt, scan_pos, scan_struck,
                             narrow_gap_r != 8'd0, wide_gap_r != 8'd0);
        if (scan_res.hit) begin
          pos_nxt = scan_res.pos;
          if (scan_res.strike) begin
            mode_nxt  = MODE_STRIKE;
            stage_nxt = STAGE_LEAD;
            wait_nxt  = strike_ticks_r;
          end else begin
            mv_req   = 1'b1;
            mv_mode  = MODE_GAP;
            mv_loops = scan_res.pos[0] ? narrow_gap_r : wide_gap_r;
          end
        end else begin
          pos_nxt = 3'd0;
          fin_req = 1'b1;
          fin_rel = rel_nxt;
          fin_emb = 1'b1;
        end
      end

      // start a motor move; an empty move ends the command at once
      if (mv_req) begin
        if (mv_loops == 8'd0) begin
          fin_req = 1'b1;
          fin_rel = 1'b1;
        end else begin
          mode_nxt  = mv_mode;
          loops_nxt = mv_loops;
          phase_nxt = 3'd0;
          wait_nxt  = step_ticks_r;
          coils_nxt = apply_phase(coils_nxt, mv_mode, 3'd0);
        end
      end

      if (fin_req) begin
        mode_nxt    = MODE_IDLE;
        striker_nxt = 1'b0;
        stage_nxt   = STAGE_LEAD;
        if (fin_rel) begin
          coils_nxt = 8'd0;
        end
        done     = 1'b1;
        done_emb = fin_emb;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ticks_r   <= 16'd50;
      strike_ticks_r <= 16'd100;
      short_feed_r   <= 8'd4;
      long_feed_r    <= 8'd7;
      indent_r       <= 8'd8;
      narrow_gap_r   <= 8'd2;
      wide_gap_r     <= 8'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP_TICKS:   step_ticks_r   <= cfg_data;
        CFG_STRIKE_TICKS: strike_ticks_r <= cfg_data;
        CFG_SHORT_FEED:   short_feed_r   <= cfg_data[7:0];
        CFG_LONG_FEED:    long_feed_r    <= cfg_data[7:0];
        CFG_INDENT:       indent_r       <= cfg_data[7:0];
        CFG_NARROW_GAP:   narrow_gap_r   <= cfg_data[7:0];
        CFG_WIDE_GAP:     wide_gap_r     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r <= in_tuser;
      s1_data_r <= in_tdata[7:0];
      s1_last_r <= in_tlast;
      s1_away_r <= in_tdata[8];
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      phase_r   <= 3'd0;
      loops_r   <= 8'd0;
      wait_r    <= 16'd0;
      pos_r     <= 3'd0;
      pattern_r <= 8'd0;
      echo_r    <= 8'd0;
      coils_r   <= 8'd0;
      striker_r <= 1'b0;
      stage_r   <= STAGE_LEAD;
      rel_r     <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      phase_r   <= phase_nxt;
      loops_r   <= loops_nxt;
      wait_r    <= wait_nxt;
      pos_r     <= pos_nxt;
      pattern_r <= pattern_nxt;
      echo_r    <= echo_nxt;
      coils_r   <= coils_nxt;
      striker_r <= striker_nxt;
      stage_r   <= stage_nxt;
      rel_r     <= rel_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      out_coil_r <= coils_nxt;
      out_sol_r  <= striker_nxt;
      out_busy_r <= (mode_nxt != MODE_IDLE);
      out_done_r <= done;
      out_echo_r <= (done && done_emb) ? echo_nxt : 8'd0;
      out_rej_r  <= rej;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_rej_r, out_echo_r, out_done_r, out_busy_r,
                       out_sol_r, out_coil_r};

`include "braille_emboss_motion_sequencer_core_macros.svh"

  // solenoid only energizes inside a strike
  `BEMS_ASSERT_IMP(a_striker_in_strike, striker_r, mode_r == MODE_STRIKE)
  // an idle sequencer has no strike in flight
  `BEMS_ASSERT_IMP(a_idle_quiet, mode_r == MODE_IDLE, !striker_r && (stage_r == STAGE_LEAD))
  // a finished command never reports busy at the same time
  `BEMS_ASSERT_IMP(a_done_not_busy, out_valid_r && out_done_r, !out_busy_r)
  // an item that moves out of the input register lands in the result register
  `BEMS_ASSERT_NXT(a_item_lands, work, out_valid_r)

endmodule
